// File: rtl/rpbs_pkg.sv
package rpbs_pkg;

  localparam int NUM_PRIORITIES_DEF = 64;
  localparam int WORD_BITS_DEF      = 32;
  localparam int MAX_PER_LEVEL_DEF  = 255;

  // Wide enough for any level position up to 511.
  localparam int POS_W = 9;

  localparam logic ACT_READY  = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic       action;
    logic [5:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [5:0] highest_ready;
    logic       none_ready;
    logic [1:0] status;
  } rsp_t;

endpackage

// File: rtl/ready_priority_bitmap_scheduler.sv
// A result passes through the update and scan states into the result register
// after its request beat is accepted. A new request is accepted only in the idle
// state, after the last one has had its count read, written back and scanned.
// The result register lets a new request enter while a result waits.
// Reset (synchronous): all level counts read as zero through per-entry valid
// bits, the bitmap clears, and no clearing pass is needed.
module ready_priority_bitmap_scheduler #(
  parameter int NUM_PRIORITIES = rpbs_pkg::NUM_PRIORITIES_DEF,
  parameter int WORD_BITS      = rpbs_pkg::WORD_BITS_DEF,
  parameter int MAX_PER_LEVEL  = rpbs_pkg::MAX_PER_LEVEL_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  rpbs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rpbs_pkg::rsp_t rsp
);
  import rpbs_pkg::*;

  localparam int NUM_WORDS = (NUM_PRIORITIES - 1) / WORD_BITS + 1;
  localparam int PRIO_W    = $clog2(NUM_PRIORITIES);
  localparam int EXT_W     = (PRIO_W > 6) ? PRIO_W : 6;
  localparam int CNT_W     = $clog2(MAX_PER_LEVEL + 1);
  localparam int LZ_W      = $clog2(WORD_BITS);

  state_t state, state_next;

  // Level count memory, read through a registered read port.
  logic [CNT_W-1:0] cnt_mem [NUM_PRIORITIES];
  logic [NUM_PRIORITIES-1:0] cnt_vld;
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_vld;

  logic [WORD_BITS-1:0] words      [NUM_WORDS];
  logic [WORD_BITS-1:0] words_next [NUM_WORDS];

  logic              req_acc;
  logic              rsp_load;
  logic [EXT_W-1:0]  prio_ext;
  logic [PRIO_W-1:0] prio_addr;
  logic              prio_in_range;

  logic              action_q;
  logic [PRIO_W-1:0] addr_q;
  logic              in_range_q;
  status_t           status_q;

  logic [CNT_W-1:0]  cnt_cur;
  logic [CNT_W-1:0]  cnt_new;
  logic              mem_we;
  logic              set_bit;
  logic              clr_bit;
  status_t           upd_status;

  logic                 found;
  logic [POS_W-1:0]     base;
  logic [WORD_BITS-1:0] sel_word;
  logic                 lz_found;
  logic [LZ_W-1:0]      lz;
  logic [POS_W-1:0]     pos;

  assign req_acc       = req_valid && !req_stall;
  assign prio_ext      = EXT_W'(req.priority_req);
  assign prio_addr     = prio_ext[PRIO_W-1:0];
  assign prio_in_range = ({3'b000, req.priority_req} < 9'(NUM_PRIORITIES));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_acc) state_next = ST_UPD;
      ST_UPD:  state_next = ST_SCAN;
      ST_SCAN: if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req_stall = 1'b1;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE: req_stall = 1'b0;
      ST_UPD:  req_stall = 1'b1;
      ST_SCAN: rsp_load  = !rsp_valid || !rsp_stall;
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request and start the count read.
  always_ff @(posedge clk) begin
    if (req_acc) begin
      action_q   <= req.action;
      addr_q     <= prio_addr;
      in_range_q <= prio_in_range;
      rd_cnt     <= cnt_mem[prio_addr];
      rd_vld     <= cnt_vld[prio_addr];
    end
    if (mem_we) begin
      cnt_mem[addr_q] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
    end else if (mem_we) begin
      cnt_vld[addr_q] <= 1'b1;
    end
  end

  // Modify the count and decide the bitmap change.
  always_comb begin
    cnt_cur    = rd_vld ? rd_cnt : '0;
    cnt_new    = cnt_cur;
    mem_we     = 1'b0;
    set_bit    = 1'b0;
    clr_bit    = 1'b0;
    upd_status = STAT_OK;
    if (state == ST_UPD && in_range_q) begin
      if (action_q == ACT_READY) begin
        set_bit = 1'b1;
        if (cnt_cur == CNT_W'(MAX_PER_LEVEL)) begin
          upd_status = STAT_FULL;
        end else begin
          cnt_new = cnt_cur + CNT_W'(1);
          mem_we  = 1'b1;
        end
      end else begin
        if (cnt_cur == '0) begin
          upd_status = STAT_EMPTY;
        end else begin
          cnt_new = cnt_cur - CNT_W'(1);
          mem_we  = 1'b1;
          clr_bit = (cnt_cur == CNT_W'(1));
        end
      end
    end
  end

  // Level l sits in word l / WORD_BITS, most significant bit first.
  always_comb begin
    words_next = words;
    for (int l = 0; l < NUM_PRIORITIES; l++) begin
      if (PRIO_W'(l) == addr_q) begin
        if (set_bit) words_next[l / WORD_BITS][WORD_BITS - 1 - (l % WORD_BITS)] = 1'b1;
        if (clr_bit) words_next[l / WORD_BITS][WORD_BITS - 1 - (l % WORD_BITS)] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) words[w] <= '0;
    end else begin
      words <= words_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      status_q <= upd_status;
    end
  end

  // Scan: first non-empty word, then leading zeros inside it.
  always_comb begin
    found    = 1'b0;
    base     = '0;
    sel_word = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (!found && (|words[w])) begin
        found    = 1'b1;
        base     = POS_W'(w * WORD_BITS);
        sel_word = words[w];
      end
    end
    lz_found = 1'b0;
    lz       = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!lz_found && sel_word[b]) begin
        lz_found = 1'b1;
        lz       = LZ_W'(WORD_BITS - 1 - b);
      end
    end
    pos = base + POS_W'(lz);
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.highest_ready <= pos[5:0];
      rsp.none_ready    <= !found;
      rsp.status        <= status_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.none_ready || rsp.highest_ready == 6'd0))
    else $error("none_ready result carries a nonzero level");

  a_full_has_ready: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STAT_FULL) |-> !rsp.none_ready)
    else $error("saturated level but bitmap reports none ready");

  a_upd_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $past(req_valid && !req_stall))
    else $error("update step without an accepted request");

  a_scan_after_upd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && $past(state) != ST_SCAN) |-> $past(state) == ST_UPD)
    else $error("scan step entered without an update");

endmodule

// File: tb/tb_ready_priority_bitmap_scheduler.sv
module tb_ready_priority_bitmap_scheduler;
  import rpbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 20;
  localparam int HOLD_AT        = 150;
  localparam int LONG_HOLD      = 400;
  localparam int SAT_INSERTS    = MAX_PER_LEVEL_DEF + 3;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  // Occupancy as the block should hold it, updated on accepted request beats
  logic [7:0] level_count [NUM_PRIORITIES_DEF];
  // Occupancy as the stimulus generator expects it, used only to shape requests
  int gen_level_count [NUM_PRIORITIES_DEF];

  int  n_errors = 0;
  int  n_recv = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  req_quiet = 1'b0;
  bit  rsp_quiet = 1'b0;

  ready_priority_bitmap_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic rsp_t predict_sched(input req_t r);
    rsp_t res;
    int   lvl;
    res.status = STAT_OK;
    if (r.action == ACT_READY) begin
      if (level_count[r.priority_req] == MAX_PER_LEVEL_DEF) begin
        res.status = STAT_FULL;
      end else begin
        level_count[r.priority_req]++;
      end
    end else if (level_count[r.priority_req] == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      level_count[r.priority_req]--;
    end
    // Lowest-numbered non-empty level wins; nothing ready reports level zero
    res.highest_ready = '0;
    res.none_ready    = 1'b1;
    for (lvl = NUM_PRIORITIES_DEF - 1; lvl >= 0; lvl--) begin
      if (level_count[lvl] != 0) begin
        res.highest_ready = 6'(lvl);
        res.none_ready    = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic queue_request(input logic act, input int prio);
    req_t r;
    r.action       = act;
    r.priority_req = 6'(prio);
    pending_reqs.push_back(r);
    if (act == ACT_READY) begin
      if (gen_level_count[prio] < MAX_PER_LEVEL_DEF) gen_level_count[prio]++;
    end else if (gen_level_count[prio] > 0) begin
      gen_level_count[prio]--;
    end
  endtask

  // Alternate filling and draining episodes over random level windows
  task automatic queue_random(input int n);
    int k, j, lo, hi, lvl, pick, start;
    bit grow;
    lo = 0;
    hi = NUM_PRIORITIES_DEF - 1;
    grow = 1'b1;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        grow = ((k / 40) % 2 == 0);
        lo = $urandom_range(0, NUM_PRIORITIES_DEF - 1);
        hi = $urandom_range(lo, NUM_PRIORITIES_DEF - 1);
        if ($urandom_range(0, 2) == 0) begin
          lo = 0;
          hi = NUM_PRIORITIES_DEF - 1;
        end
      end
      if ($urandom_range(0, 99) < (grow ? 65 : 25)) begin
        queue_request(ACT_READY, $urandom_range(lo, hi));
      end else begin
        pick = $urandom_range(0, 9);
        lvl = $urandom_range(0, NUM_PRIORITIES_DEF - 1);
        // Mostly remove from a busy level, usually the most urgent one
        if (pick < 9) begin
          start = (pick < 6) ? 0 : lvl;
          for (j = 0; j < NUM_PRIORITIES_DEF; j++) begin
            if (gen_level_count[(start + j) % NUM_PRIORITIES_DEF] != 0) begin
              lvl = (start + j) % NUM_PRIORITIES_DEF;
              break;
            end
          end
        end
        queue_request(ACT_REMOVE, lvl);
      end
    end
  endtask

  task automatic flag_mismatch(input string what);
    if (n_errors < 10) $display("%s", what);
    n_errors++;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(predict_sched(req));
        if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
        gap_left = req_quiet ? 0 : $urandom_range(0, 6);
      end
      // Hold a stalled beat as it is
      if (!(req_valid && req_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat: highest=%0d none=%0b status=%0d",
                                  rsp.highest_ready, rsp.none_ready, rsp.status));
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp.highest_ready !== exp_rsp.highest_ready)
            flag_mismatch($sformatf("beat %0d highest_ready: expected %0d, got %0d",
                                    n_recv, exp_rsp.highest_ready, rsp.highest_ready));
          if (rsp.none_ready !== exp_rsp.none_ready)
            flag_mismatch($sformatf("beat %0d none_ready: expected %0b, got %0b",
                                    n_recv, exp_rsp.none_ready, rsp.none_ready));
          if (rsp.status !== exp_rsp.status)
            flag_mismatch($sformatf("beat %0d status: expected %0d, got %0d",
                                    n_recv, exp_rsp.status, rsp.status));
        end
        n_recv++;
        if ($urandom_range(0, 29) == 0) rsp_quiet = !rsp_quiet;
        // Back up the block once so that it stalls its input
        if (n_recv == HOLD_AT) stall_left = LONG_HOLD;
        else stall_left = rsp_quiet ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      rsp_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int sat_lvl;
    for (int i = 0; i < NUM_PRIORITIES_DEF; i++) begin
      level_count[i] = '0;
      gen_level_count[i] = 0;
    end

    // Empty removes at both ends, word boundaries, repeat inserts, drain to none
    queue_request(ACT_REMOVE, 0);
    queue_request(ACT_REMOVE, 63);
    queue_request(ACT_READY, 63);
    queue_request(ACT_READY, 32);
    queue_request(ACT_READY, 31);
    queue_request(ACT_READY, 0);
    queue_request(ACT_READY, 0);
    queue_request(ACT_REMOVE, 0);
    queue_request(ACT_REMOVE, 0);
    queue_request(ACT_REMOVE, 31);
    queue_request(ACT_REMOVE, 32);
    queue_request(ACT_REMOVE, 32);
    queue_request(ACT_READY, 1);
    queue_request(ACT_REMOVE, 63);
    queue_request(ACT_REMOVE, 1);
    queue_request(ACT_READY, 33);
    queue_request(ACT_READY, 62);
    queue_request(ACT_REMOVE, 33);
    queue_request(ACT_REMOVE, 62);

    queue_random(640);

    // Saturate one level, back off a little and hit the ceiling again
    sat_lvl = $urandom_range(0, NUM_PRIORITIES_DEF - 1);
    repeat (SAT_INSERTS) queue_request(ACT_READY, sat_lvl);
    repeat (4) queue_request(ACT_REMOVE, sat_lvl);
    repeat (5) queue_request(ACT_READY, sat_lvl);
    queue_random(20);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sample at the falling edge so the queues and valids have settled
    while (!(pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(negedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (n_errors == 0 && expected_rsps.size() == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
    end
    $finish;
  end

endmodule
